>>> src/kfg_pkg.sv
// kfg_pkg: shared types, codes and constants of the keypad function generator
// holds the sine table builder used by kfg_back at elaboration
// depends on nothing
package kfg_pkg;

    localparam logic [1:0] OP_WAVE = 2'd0;
    localparam logic [1:0] OP_TONE = 2'd1;
    localparam logic [1:0] OP_KEY  = 2'd2;

    localparam logic [1:0] MODE_SINE = 2'd0;
    localparam logic [1:0] MODE_SAW  = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;
    localparam logic [1:0] MODE_OFF  = 2'd3;

    localparam logic [15:0] TONE_LENGTH_RESET = 16'd300;
    localparam int unsigned PERIOD_RESET = 5000;
    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598669;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] key_sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] dac_code;
        logic       tone_level;
        logic [1:0] wave_mode;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_WAVE,
        CMD_TONE,
        CMD_DIGIT,
        CMD_DOUBLE,
        CMD_HALVE,
        CMD_OFF,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic       set_mode;
        logic [1:0] mode;
        logic [5:0] code;
    } t_cmd;

    // shift-subtract quotient, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi/2 * u), q30 in and out
    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] s;
        u2 = (u * u) >> 30;
        s  = SIN_C7 - ((u2 * SIN_C9) >> 30);
        s  = SIN_C5 - ((u2 * s) >> 30);
        s  = SIN_C3 - ((u2 * s) >> 30);
        s  = SIN_C1 - ((u2 * s) >> 30);
        return (u * s) >> 30;
    endfunction

    function automatic logic [7:0] sine_entry(input int unsigned k, input int unsigned entries);
        logic [63:0] f;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] v;
        f    = udiv64(64'(k) << 32, 64'(entries));
        quad = (f >> 30) & 64'd3;
        r    = f & (Q30_ONE - 64'd1);
        u    = quad[0] ? (Q30_ONE - r) : r;
        s    = quarter_sine(u);
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        if (quad < 64'd2) begin
            v = (64'd255 * (Q30_ONE + s)) >> 31;
        end else begin
            v = (64'd255 * (Q30_ONE - s)) >> 31;
        end
        if (v > 64'd255) begin
            v = 64'd255;
        end
        return v[7:0];
    endfunction

endpackage

>>> src/kfg_front.sv
// kfg_front: accepts input transactions and classifies them into commands
// depends on kfg_pkg; feeds kfg_queue
module kfg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  kfg_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    input  logic              i_full,
    output logic              o_push,
    output kfg_pkg::t_cmd     o_cmd
);

    logic       r_seen;
    logic [9:0] v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_push) begin
            r_seen <= 1'b1;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && (r_seen || 1'b1);
    assign v          = i_in_data.key_sample;

    always_comb begin
        o_cmd.kind     = kfg_pkg::CMD_NOP;
        o_cmd.set_mode = 1'b0;
        o_cmd.mode     = kfg_pkg::MODE_OFF;
        o_cmd.code     = 6'd0;
        case (i_in_data.operation)
            kfg_pkg::OP_WAVE: o_cmd.kind = kfg_pkg::CMD_WAVE;
            kfg_pkg::OP_TONE: o_cmd.kind = kfg_pkg::CMD_TONE;
            kfg_pkg::OP_KEY: begin
                o_cmd.kind = kfg_pkg::CMD_DIGIT;
                if (v > 10'd465 && v < 10'd520) begin
                    o_cmd.set_mode = 1'b1;
                    o_cmd.mode     = kfg_pkg::MODE_SINE;
                    o_cmd.code     = 6'd34;
                end else if (v > 10'd360 && v < 10'd380) begin
                    o_cmd.set_mode = 1'b1;
                    o_cmd.mode     = kfg_pkg::MODE_SAW;
                    o_cmd.code     = 6'd32;
                end else if (v > 10'd198 && v < 10'd208) begin
                    o_cmd.set_mode = 1'b1;
                    o_cmd.mode     = kfg_pkg::MODE_TRI;
                    o_cmd.code     = 6'd30;
                end else if (v > 10'd450 && v < 10'd460) begin
                    o_cmd.code = 6'd32;
                end else if (v > 10'd330 && v < 10'd340) begin
                    o_cmd.code = 6'd30;
                end else if (v > 10'd140 && v < 10'd150) begin
                    o_cmd.code = 6'd29;
                end else if (v > 10'd420 && v < 10'd432) begin
                    o_cmd.code = 6'd32;
                end else if (v > 10'd290 && v < 10'd300) begin
                    o_cmd.code = 6'd29;
                end else if (v > 10'd70 && v < 10'd80) begin
                    o_cmd.code = 6'd27;
                end else if (v > 10'd390 && v < 10'd410) begin
                    o_cmd.kind = kfg_pkg::CMD_DOUBLE;
                end else if (v > 10'd240 && v < 10'd250) begin
                    o_cmd.kind = kfg_pkg::CMD_HALVE;
                end else if (v == 10'd0) begin
                    o_cmd.kind = kfg_pkg::CMD_OFF;
                end else begin
                    o_cmd.kind = kfg_pkg::CMD_NOP;
                end
            end
            default: o_cmd.kind = kfg_pkg::CMD_NOP;
        endcase
    end

endmodule

>>> src/kfg_queue.sv
// kfg_queue: short command queue between front and back
// depends on kfg_pkg
module kfg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kfg_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output kfg_pkg::t_cmd o_data
);

    localparam int unsigned DEPTH = kfg_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    kfg_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/kfg_back.sv
// kfg_back: executes commands, holds generator state and the result register
// depends on kfg_pkg; sine table built at elaboration, wave value by shift-subtract divide
module kfg_back #(
    parameter int unsigned PERIOD_BITS  = 24,
    parameter int unsigned SINE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  kfg_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    output logic               o_cfg_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kfg_pkg::t_out_item o_out_data
);

    localparam int unsigned PB = PERIOD_BITS;
    localparam int unsigned IW = $clog2(SINE_ENTRIES);
    localparam int unsigned QW = (IW > 8) ? IW : 8;
    localparam int unsigned XW = PB + QW + 1;
    localparam int unsigned CW = $clog2(QW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MAP
    } t_state;

    logic [7:0] sine_rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        assign sine_rom[g] = kfg_pkg::sine_entry(g, SINE_ENTRIES);
    end

    t_state             r_state, n_state;
    logic [15:0]        r_tone_length, n_tone_length;
    logic [PB-1:0]      r_phase, n_phase;
    logic [PB-1:0]      r_period, n_period;
    logic [PB-1:0]      r_per, n_per;
    logic [1:0]         r_mode, n_mode;
    logic [5:0]         r_half_code, n_half_code;
    logic [15:0]        r_tone_count, n_tone_count;
    logic [15:0]        r_tone_remaining, n_tone_remaining;
    logic               r_tone_pin, n_tone_pin;
    logic [7:0]         r_dac, n_dac;
    logic [XW-1:0]      r_rem, n_rem;
    logic [XW-1:0]      r_div, n_div;
    logic [QW-1:0]      r_quo, n_quo;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    kfg_pkg::t_out_item r_out_data, n_out_data;

    logic          out_free;
    logic [PB-1:0] per_eff;
    logic [PB:0]   period_dbl;
    logic [PB-1:0] period_half;
    logic [PB-1:0] phase_inc;
    logic [15:0]   tone_inc;
    logic [XW-1:0] p_x;
    logic [XW-1:0] saw_x;
    logic [XW-1:0] tri_x;
    logic [IW-1:0] rom_idx;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign per_eff     = (r_period < PB'(2)) ? PB'(2) : r_period;
    assign period_dbl  = {r_period, 1'b0};
    assign period_half = r_period >> 1;
    assign phase_inc   = r_phase + 1'b1;
    assign tone_inc    = r_tone_count + 1'b1;
    assign p_x         = XW'(r_phase);
    assign saw_x       = (p_x << 8) - p_x;
    assign tri_x       = ((XW'(r_per - r_phase)) << 9) - ((XW'(r_per - r_phase)) << 1);
    // phase below period keeps the quotient below the table size
    assign rom_idx     = r_quo[IW-1:0];

    always_comb begin
        n_state          = r_state;
        n_tone_length    = r_tone_length;
        n_phase          = r_phase;
        n_period         = r_period;
        n_per            = r_per;
        n_mode           = r_mode;
        n_half_code      = r_half_code;
        n_tone_count     = r_tone_count;
        n_tone_remaining = r_tone_remaining;
        n_tone_pin       = r_tone_pin;
        n_dac            = r_dac;
        n_rem            = r_rem;
        n_div            = r_div;
        n_quo            = r_quo;
        n_cnt            = r_cnt;
        n_out_valid      = r_out_valid && i_out_stall;
        n_out_data       = r_out_data;
        o_cmd_pop        = 1'b0;

        if (i_cfg_valid) begin
            n_tone_length = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        kfg_pkg::CMD_WAVE: begin
                            n_per   = per_eff;
                            n_phase = (r_phase >= per_eff) ? '0 : r_phase;
                            n_state = S_LOAD;
                        end
                        kfg_pkg::CMD_TONE: begin
                            n_tone_count = tone_inc;
                            if (tone_inc >= 16'(r_half_code >> 1) && r_tone_remaining > 16'd1)
                            begin
                                n_tone_pin       = !r_tone_pin;
                                n_tone_count     = '0;
                                n_tone_remaining = r_tone_remaining - 1'b1;
                            end
                        end
                        kfg_pkg::CMD_DIGIT: begin
                            if (i_cmd.set_mode) begin
                                n_mode = i_cmd.mode;
                            end
                            n_half_code      = i_cmd.code;
                            n_tone_remaining = r_tone_length;
                        end
                        kfg_pkg::CMD_DOUBLE: begin
                            n_period = period_dbl[PB] ? '1 : period_dbl[PB-1:0];
                        end
                        kfg_pkg::CMD_HALVE: begin
                            n_period = (period_half < PB'(2)) ? PB'(2) : period_half;
                        end
                        kfg_pkg::CMD_OFF: n_mode = kfg_pkg::MODE_OFF;
                        default: n_mode = r_mode;
                    endcase
                    if (i_cmd.kind != kfg_pkg::CMD_WAVE) begin
                        n_out_valid           = 1'b1;
                        n_out_data.dac_code   = r_dac;
                        n_out_data.tone_level = n_tone_pin;
                        n_out_data.wave_mode  = n_mode;
                    end
                end
            end
            S_LOAD: begin
                case (r_mode)
                    kfg_pkg::MODE_SINE: n_rem = p_x * XW'(SINE_ENTRIES);
                    kfg_pkg::MODE_SAW:  n_rem = saw_x;
                    kfg_pkg::MODE_TRI: begin
                        if ({r_phase, 1'b0} < {1'b0, r_per}) begin
                            n_rem = saw_x << 1;
                        end else begin
                            n_rem = tri_x;
                        end
                    end
                    default: n_rem = '0;
                endcase
                n_div   = XW'(r_per) << (QW - 1);
                n_quo   = '0;
                n_cnt   = CW'(QW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_rem >= r_div) begin
                    n_rem = r_rem - r_div;
                end
                n_quo = {r_quo[QW-2:0], (r_rem >= r_div)};
                n_div = r_div >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (out_free) begin
                    case (r_mode)
                        kfg_pkg::MODE_SINE: n_dac = sine_rom[rom_idx];
                        kfg_pkg::MODE_OFF:  n_dac = 8'd0;
                        default:            n_dac = r_quo[7:0];
                    endcase
                    n_phase               = (phase_inc >= r_per) ? '0 : phase_inc;
                    n_out_valid           = 1'b1;
                    n_out_data.dac_code   = n_dac;
                    n_out_data.tone_level = r_tone_pin;
                    n_out_data.wave_mode  = r_mode;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_tone_length    <= kfg_pkg::TONE_LENGTH_RESET;
            r_phase          <= '0;
            r_period         <= PB'(kfg_pkg::PERIOD_RESET);
            r_mode           <= kfg_pkg::MODE_OFF;
            r_half_code      <= '0;
            r_tone_count     <= '0;
            r_tone_remaining <= '0;
            r_tone_pin       <= 1'b0;
            r_dac            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_tone_length    <= n_tone_length;
            r_phase          <= n_phase;
            r_period         <= n_period;
            r_mode           <= n_mode;
            r_half_code      <= n_half_code;
            r_tone_count     <= n_tone_count;
            r_tone_remaining <= n_tone_remaining;
            r_tone_pin       <= n_tone_pin;
            r_dac            <= n_dac;
            r_out_valid      <= n_out_valid;
        end
        r_per      <= n_per;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

endmodule

>>> src/keypad_function_generator.sv
// keypad_function_generator: top level, front classifier, command queue and back end
// depends on kfg_pkg, kfg_front, kfg_queue, kfg_back
//
// One result transaction per input transaction, in order. Tone ticks, keypad
// samples and the unused operation are executed in the back end's idle state
// as they are popped. A wave tick is picked up, its scaled phase is formed,
// the shift-subtract divider divides it by the period at one quotient bit per
// cycle into a max(8, clog2(SINE_ENTRIES)) bit quotient, and that is mapped
// through the sine table or straight to the DAC code, once the output is free.
// The front end keeps accepting into a four-deep command queue while the back
// end works or its result waits. tone_length is written through the cfg
// channel, which is always ready.
module keypad_function_generator #(
    parameter int unsigned PERIOD_BITS  = 24,
    parameter int unsigned SINE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  kfg_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kfg_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    output logic               o_cfg_ready
);

    logic          q_full;
    logic          q_push;
    kfg_pkg::t_cmd q_in;
    logic          q_valid;
    logic          q_pop;
    kfg_pkg::t_cmd q_out;

    kfg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    kfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    kfg_back #(
        .PERIOD_BITS  (PERIOD_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
